FILE: hw/rtl/rcma_pkg.sv
// Shared types, constants and register indexes for the relay contact mismatch alarm.
package rcma_pkg;

    // Default sizing of the alarm tables.
    localparam int MODULE_COUNT_DEF = 16;
    localparam int LOOP_COUNT_DEF   = 16;

    // Field widths fixed by the beat formats.
    localparam int MOD_W   = 4;
    localparam int LOOP_W  = 4;
    localparam int MASK_W  = 16;
    localparam int TRIP_W  = 7;
    localparam int CNT_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP_COUNT   = 1'b1;

    // Register reset values.
    localparam logic [TRIP_W-1:0] TRIP_RESET = 7'd10;

    // One poll of one relay loop.
    typedef struct packed {
        logic [MOD_W-1:0]  module_req;
        logic [LOOP_W-1:0] loop;
        logic              loop_enabled;
        logic              input_found;
        logic              output_bit;
        logic              input_bit;
        logic              invert;
        logic              last_loop;
    } t_poll;

    // One module report.
    typedef struct packed {
        logic [MOD_W-1:0]  report_module;
        logic              alarm_active;
        logic [MASK_W-1:0] loop_alarm_mask;
    } t_rpt;

    // Inputs of one counter qualification step.
    typedef struct packed {
        logic signed [CNT_W-1:0] cnt;
        logic                    raised;
        logic                    mismatch;
        logic [TRIP_W-1:0]       trip;
    } t_qual_in;

    // Outcome of one counter qualification step.
    typedef struct packed {
        logic signed [CNT_W-1:0] cnt;
        logic                    set;
        logic                    clr;
    } t_qual_res;

endpackage

FILE: hw/rtl/rcma_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
interface rcma_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/rcma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rcma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/rcma_qualify.sv
// One step of the signed mismatch qualify counter of a relay loop.
module rcma_qualify (
    input  rcma_pkg::t_qual_in  i_q,
    output rcma_pkg::t_qual_res o_res
);

    logic signed [rcma_pkg::CNT_W:0] c9;
    logic signed [rcma_pkg::CNT_W:0] trip9;
    logic signed [rcma_pkg::CNT_W:0] sum9;

    assign c9    = {i_q.cnt[rcma_pkg::CNT_W-1], i_q.cnt};
    assign trip9 = {{(rcma_pkg::CNT_W + 1 - rcma_pkg::TRIP_W){1'b0}}, i_q.trip};
    assign sum9  = i_q.raised ? (c9 - 9'sd1) : (c9 + 9'sd1);

    // Count toward the alarm while clear and toward clearing while raised;
    // an opposite reading restarts the count from zero.
    always_comb begin
        o_res.cnt = '0;
        o_res.set = 1'b0;
        o_res.clr = 1'b0;
        if (!i_q.raised) begin
            if (i_q.mismatch) begin
                if (sum9 >= trip9) begin
                    o_res.cnt = trip9[rcma_pkg::CNT_W-1:0];
                    o_res.set = 1'b1;
                end else begin
                    o_res.cnt = sum9[rcma_pkg::CNT_W-1:0];
                end
            end
        end else begin
            if (!i_q.mismatch) begin
                if (sum9 <= -trip9) begin
                    o_res.cnt = 8'(-trip9);
                    o_res.clr = 1'b1;
                end else begin
                    o_res.cnt = sum9[rcma_pkg::CNT_W-1:0];
                end
            end
        end
    end

endmodule

FILE: hw/rtl/relay_contact_mismatch_alarm.sv
// Top level of the relay contact mismatch alarm.
//
// Usage:
//   i_poll carries one beat per poll of one relay loop. o_rpt carries a beat
//   only when a poll marked as a module's last loop finds a pending alarm
//   change for that module; that beat gives the module's fault mask.
//   Configuration goes through i_cfg_we, i_cfg_idx and i_cfg_data, written
//   while the block is idle.
// Throughput and pipeline:
//   One poll beat is accepted every cycle unless a stall drops i_poll.ready.
//   The accepting edge starts the counter RAM read; the output register is
//   loaded after the qualify step, once the output slot is free.
// Reset:
//   Synchronous, active low. Alarms are disabled, trip count is 10, and all
//   counters, masks and pending flags read as zero at once (counter entries
//   carry valid bits, so no clearing pass is needed).
// Stalls:
//   When o_rpt is held off, the report waits in the output register and the
//   next poll waits in the stage behind it; i_poll.ready drops once both are
//   full and rises in the cycle that the receiver takes the report.
module relay_contact_mismatch_alarm #(
    parameter int MODULE_COUNT = rcma_pkg::MODULE_COUNT_DEF,
    parameter int LOOP_COUNT   = rcma_pkg::LOOP_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rcma_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rcma_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rcma_stream_if.sink                       i_poll,
    rcma_stream_if.source                     o_rpt
);

    // Only modules reachable with the index width get storage.
    localparam int MODS      = (MODULE_COUNT < (1 << rcma_pkg::MOD_W)) ?
                               MODULE_COUNT : (1 << rcma_pkg::MOD_W);
    localparam int MB        = (MODS > 1) ? $clog2(MODS) : 1;
    localparam int LB        = (LOOP_COUNT > 1) ? $clog2(LOOP_COUNT) : 1;
    localparam int CNT_DEPTH = MODS << LB;
    localparam int AW        = MB + LB;

    // Configuration registers.
    logic                        r_enable;
    logic [rcma_pkg::TRIP_W-1:0] r_trip;

    // Pipeline registers.
    logic                 r_s1_valid;
    rcma_pkg::t_poll      r_s1_data;
    logic                 r_out_valid;
    rcma_pkg::t_rpt       r_out_data;

    // Per-module state and per-entry counter valid bits.
    logic [LOOP_COUNT-1:0] r_fmask [MODS];
    logic [MODS-1:0]       r_pend;
    logic [CNT_DEPTH-1:0]  r_cnt_vld;

    // Last counter write, forwarded to the poll that enters as it is written.
    logic                          r_byp_valid;
    logic [AW-1:0]                 r_byp_addr;
    logic signed [rcma_pkg::CNT_W-1:0] r_byp_data;

    logic                          in_fire;
    logic                          s1_adv;
    logic                          s1_fire;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 s1_addr;
    logic [MB-1:0]                 m_idx;
    logic [LB-1:0]                 l_idx;
    logic                          m_ok;
    logic                          l_ok;
    logic                          live;
    logic                          do_q;
    logic [rcma_pkg::CNT_W-1:0]    ram_q;
    logic signed [rcma_pkg::CNT_W-1:0] cur_cnt;
    rcma_pkg::t_qual_in            q_in;
    rcma_pkg::t_qual_res           q_res;
    logic [LOOP_COUNT-1:0]         cur_mask;
    logic [LOOP_COUNT-1:0]         mask_next;
    logic                          pend_next;
    logic                          emit;
    rcma_pkg::t_rpt                rpt_next;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_trip   <= rcma_pkg::TRIP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcma_pkg::REG_ALARM_ENABLE: r_enable <= i_cfg_data[0];
                rcma_pkg::REG_TRIP_COUNT:   r_trip   <= i_cfg_data;
                default:                    r_enable <= r_enable;
            endcase
        end
    end

    // Handshakes: the qualify stage moves whenever the output slot is free.
    assign s1_adv       = !r_out_valid || o_rpt.ready;
    assign s1_fire      = r_s1_valid && s1_adv;
    assign i_poll.ready = !r_s1_valid || s1_adv;
    assign in_fire      = i_poll.valid && i_poll.ready;

    // Counter RAM read address for the incoming beat.
    assign rd_addr = {i_poll.data.module_req[MB-1:0], i_poll.data.loop[LB-1:0]};

    rcma_ram #(
        .WIDTH (rcma_pkg::CNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire && do_q),
        .i_waddr (s1_addr),
        .i_wdata (q_res.cnt),
        .i_re    (in_fire),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Input stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_poll.ready) begin
            r_s1_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_data <= i_poll.data;
        end
    end

    // Decode of the poll in the qualify stage.
    assign m_idx   = r_s1_data.module_req[MB-1:0];
    assign l_idx   = r_s1_data.loop[LB-1:0];
    assign s1_addr = {m_idx, l_idx};
    assign m_ok    = {5'b0, r_s1_data.module_req} < 9'(MODULE_COUNT);
    assign l_ok    = {1'b0, r_s1_data.loop} < 5'(LOOP_COUNT);
    assign live    = r_enable && m_ok;
    assign do_q    = live && l_ok && r_s1_data.loop_enabled && r_s1_data.input_found;

    // Current counter: unwritten entries read as zero, a write made as this
    // beat entered comes from the bypass register.
    always_comb begin
        if (!r_cnt_vld[s1_addr]) begin
            cur_cnt = '0;
        end else if (r_byp_valid && (r_byp_addr == s1_addr)) begin
            cur_cnt = r_byp_data;
        end else begin
            cur_cnt = ram_q;
        end
    end

    // The loop alarm flag is the loop's bit of the module fault mask.
    assign cur_mask      = r_fmask[m_idx];
    assign q_in.cnt      = cur_cnt;
    assign q_in.raised   = cur_mask[l_idx];
    assign q_in.mismatch = r_s1_data.output_bit ^ r_s1_data.input_bit ^ r_s1_data.invert;
    assign q_in.trip     = r_trip;

    rcma_qualify u_qualify (
        .i_q   (q_in),
        .o_res (q_res)
    );

    // Mask and report decision.
    always_comb begin
        mask_next = cur_mask;
        if (do_q && q_res.set) begin
            mask_next[l_idx] = 1'b1;
        end else if (do_q && q_res.clr) begin
            mask_next[l_idx] = 1'b0;
        end
    end

    assign pend_next = r_pend[m_idx] || (do_q && (q_res.set || q_res.clr));
    assign emit      = live && r_s1_data.last_loop && pend_next;

    assign rpt_next.report_module   = r_s1_data.module_req;
    assign rpt_next.alarm_active    = |mask_next;
    assign rpt_next.loop_alarm_mask = rcma_pkg::MASK_W'(mask_next);

    // State updates of a processed poll.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_cnt_vld   <= '0;
            r_byp_valid <= 1'b0;
            for (int i = 0; i < MODS; i++) begin
                r_fmask[i] <= '0;
            end
        end else if (s1_fire) begin
            if (live) begin
                r_fmask[m_idx] <= mask_next;
                r_pend[m_idx]  <= pend_next && !emit;
            end
            if (do_q) begin
                r_cnt_vld[s1_addr] <= 1'b1;
                r_byp_valid        <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && do_q) begin
            r_byp_addr <= s1_addr;
            r_byp_data <= q_res.cnt;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= s1_fire && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && emit) begin
            r_out_data <= rpt_next;
        end
    end

    assign o_rpt.valid = r_out_valid;
    assign o_rpt.data  = r_out_data;

`ifndef NO_ASSERTIONS
    // A report's active flag agrees with the mask it carries.
    a_active_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.alarm_active == (|r_out_data.loop_alarm_mask)))
        else $error("report active flag disagrees with its mask");

    // While alarms are disabled, a processed poll never produces a report.
    a_no_report_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && !r_enable) |=> !r_out_valid)
        else $error("report produced while alarms are disabled");

    // Stored counters stay within the range that a seven-bit threshold allows.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byp_valid |-> (r_byp_data != 8'sh80))
        else $error("qualify counter out of range");

    // A report produced for a module clears that module's pending flag.
    a_pend_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && emit) |=> !r_pend[$past(m_idx)])
        else $error("pending flag not cleared after report");
`endif

endmodule
